### design/assert_macros.svh
// Assertion macros for the design file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define GLJ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define GLJ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gljust_pkg.sv
// Shared types and constants of the greedy line justifier.
package gljust_pkg;

  localparam int LEN_W          = 7;
  localparam int MAX_LINE       = 64;
  localparam int DEF_MAX_WORDS  = 32;
  localparam int LINE_RESET     = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [ADDR_W-3:0] REG_LINE_WIDTH = '0;

  typedef struct packed {
    logic [LEN_W-1:0] word_length;
    logic             final_word;
  } word_t;

  typedef struct packed {
    logic [LEN_W-1:0] placed_length;
    logic [LEN_W-1:0] spaces_after;
    logic             line_end;
    logic             too_long;
    logic             run_end;
  } place_t;

  typedef struct packed {
    logic capture;
    logic drop_step;
    logic err;
    logic flush_start;
    logic last_line;
    logic div_start;
    logic emit;
    logic flush_done;
    logic append;
  } cmd_t;

  typedef struct packed {
    logic dropping;
    logic too_long;
    logic empty;
    logic fin;
    logic need_flush;
    logic has_words;
    logic multi;
    logic div_busy;
    logic last_word;
    logic out_free;
  } sts_t;

endpackage

### design/greedy_line_justifier.sv
// Greedy full-justification line packer: one word in, one result per placed or over-long word out.
// Each item is taken only while the block is idle, so a new word waits until the last is through.
// A line flush reads the buffered words out one at a time, first running the bit-serial
// divider when a justified line of two or more words spreads its slack.
// Words are held in a buffer with one write and one read port, read one entry per flush step.
// Synchronous reset clears the line state, the drop mode and sets line_width to 16.
`include "assert_macros.svh"

module greedy_line_justifier import gljust_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_valid,
  output logic              word_ready,
  input  word_t             word,
  output logic              result_valid,
  input  logic              result_ready,
  output place_t            result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] line_width;
  logic             hit_line_width;
  cmd_t             cmd;
  sts_t             sts;

  assign pready         = 1'b1;
  assign hit_line_width = paddr[ADDR_W-1:2] == REG_LINE_WIDTH;
  assign prdata         = hit_line_width ? {{(DATA_W-LEN_W){1'b0}}, line_width} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LEN_W'(LINE_RESET);
    end else if (psel && penable && pwrite && pready && hit_line_width) begin
      line_width <= pwdata[LEN_W-1:0];
    end
  end

  gljust_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .word_valid(word_valid),
    .word_ready(word_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gljust_dp #(.MAX_WORDS(MAX_WORDS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .word        (word),
    .line_width  (line_width),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  `GLJ_ASSERT(a_busy_after_accept, clk, rst, word_valid && word_ready |=> !word_ready, "block took a second item at once")
  `GLJ_ASSERT(a_error_shape, clk, rst, result_valid && result.too_long |-> result.run_end && !result.line_end && result.spaces_after == '0, "malformed error result")
  `GLJ_ASSERT(a_no_empty_word, clk, rst, result_valid && !result.too_long |-> result.placed_length != '0, "empty word placed")
  `GLJ_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !result_valid, "result valid right after reset")

endmodule

### design/gljust_div.sv
// Restoring divider, one quotient bit per cycle, for spreading slack over gaps.
module gljust_div import gljust_pkg::*; #(
  parameter int DW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LEN_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             busy,
  output logic [LEN_W-1:0] quotient,
  output logic [DW-1:0]    remainder
);

  localparam int STEP_W = $clog2(LEN_W);

  logic [LEN_W-1:0]  q;
  logic [DW-1:0]     r;
  logic [DW-1:0]     d;
  logic [STEP_W-1:0] steps;
  logic [DW:0]       trial;
  logic              take;

  assign trial = {r, q[LEN_W-1]};
  assign take  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= '0;
    end else if (busy) begin
      steps <= steps + STEP_W'(1);
      if (steps == STEP_W'(LEN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (take) begin
        r <= DW'(trial - {1'b0, d});
        q <= {q[LEN_W-2:0], 1'b1};
      end else begin
        r <= trial[DW-1:0];
        q <= {q[LEN_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

### design/gljust_dp.sv
// Datapath: word buffer, line state, slack divider and result register.
module gljust_dp import gljust_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic             clk,
  input  logic             rst,
  input  word_t            word,
  input  logic [LEN_W-1:0] line_width,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             result_valid,
  input  logic             result_ready,
  output place_t           result
);

  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [LEN_W-1:0] len;
  logic             fin;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] pw;
  logic             dropping;
  logic [LEN_W-1:0] lengths [MAX_WORDS];
  logic [LEN_W-1:0] rd_len;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] idx_ext;
  logic [LEN_W-1:0] slack;
  logic [LEN_W-1:0] slack_now;
  logic             last_line;
  logic [LEN_W-1:0] width_eff;
  logic [LEN_W:0]   fit_sum;
  logic [CNT_W-1:0] gaps;
  logic [LEN_W-1:0] quot;
  logic [CNT_W-1:0] rmd;
  logic             div_busy;
  logic             last_word;
  logic [LEN_W-1:0] spaces;

  always_comb begin
    if (line_width == '0) begin
      width_eff = LEN_W'(1);
    end else if (line_width > LEN_W'(MAX_LINE)) begin
      width_eff = LEN_W'(MAX_LINE);
    end else begin
      width_eff = line_width;
    end
  end

  assign fit_sum   = {1'b0, pw} + (LEN_W+1)'(1) + {1'b0, len};
  assign slack_now = (pw < width_eff) ? width_eff - pw : '0;
  assign gaps      = count - CNT_W'(1);
  assign idx_ext   = CNT_W'(idx);
  assign last_word = idx_ext == gaps;

  // A single-word line is padded after its word, like the final line.
  // A justified line gets the even share plus one more on the leftmost gaps.
  always_comb begin
    if (last_line || gaps == '0) begin
      spaces = last_word ? slack : LEN_W'(1);
    end else if (last_word) begin
      spaces = '0;
    end else begin
      spaces = LEN_W'(1) + quot + ((idx_ext < rmd) ? LEN_W'(1) : LEN_W'(0));
    end
  end

  gljust_div #(.DW(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (slack_now),
    .divisor  (gaps),
    .busy     (div_busy),
    .quotient (quot),
    .remainder(rmd)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len <= word.word_length;
      fin <= word.final_word;
    end
    if (cmd.flush_start) begin
      idx       <= '0;
      slack     <= slack_now;
      last_line <= cmd.last_line;
    end else if (cmd.emit) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      lengths[count[IDX_W-1:0]] <= len;
    end
    rd_len <= lengths[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pw       <= '0;
      dropping <= 1'b0;
    end else begin
      if (cmd.drop_step && fin) begin
        dropping <= 1'b0;
      end
      if (cmd.err) begin
        count    <= '0;
        pw       <= '0;
        dropping <= !fin;
      end
      if (cmd.flush_done) begin
        count <= '0;
        pw    <= '0;
      end
      if (cmd.append) begin
        count <= count + CNT_W'(1);
        pw    <= (count == '0) ? len : fit_sum[LEN_W-1:0];
      end
    end
  end

  assign sts.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sts.out_free) begin
      result_valid <= cmd.emit || cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.placed_length <= rd_len;
      result.spaces_after  <= spaces;
      result.line_end      <= last_word;
      result.too_long      <= 1'b0;
      // A justified line followed by a final line is not the end of the run.
      result.run_end       <= last_word && (last_line || !fin);
    end else if (cmd.err) begin
      result.placed_length <= len;
      result.spaces_after  <= '0;
      result.line_end      <= 1'b0;
      result.too_long      <= 1'b1;
      result.run_end       <= 1'b1;
    end
  end

  assign sts.dropping   = dropping;
  assign sts.too_long   = len > width_eff;
  assign sts.empty      = len == '0;
  assign sts.fin        = fin;
  assign sts.need_flush = (count != '0) &&
                          ((fit_sum > {1'b0, width_eff}) || (count >= CNT_W'(MAX_WORDS)));
  assign sts.has_words  = count != '0;
  assign sts.multi      = count > CNT_W'(1);
  assign sts.div_busy   = div_busy;
  assign sts.last_word  = last_word;

endmodule

### design/gljust_ctrl.sv
// Controller: sequences decode, error, line flush and buffering of each item.
module gljust_ctrl import gljust_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic word_valid,
  output logic word_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_ERROR  = 8'b0000_0100,
    S_FLUSH  = 8'b0000_1000,
    S_DIVIDE = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_APPEND = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   final_pass, final_pass_next;

  assign word_ready = state == S_IDLE;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    final_pass_next = final_pass;
    case (state)
      S_IDLE: begin
        if (word_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.dropping) begin
          cmd.drop_step = 1'b1;
          state_next    = S_IDLE;
        end else if (sts.too_long) begin
          state_next = S_ERROR;
        end else if (sts.empty) begin
          if (sts.fin && sts.has_words) begin
            final_pass_next = 1'b1;
            state_next      = S_FLUSH;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.need_flush) begin
          final_pass_next = 1'b0;
          state_next      = S_FLUSH;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_ERROR: begin
        if (sts.out_free) begin
          cmd.err    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.flush_start = 1'b1;
        cmd.last_line   = final_pass;
        if (sts.multi && !final_pass) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVIDE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DIVIDE: begin
        if (!sts.div_busy) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_word) begin
            cmd.flush_done = 1'b1;
            state_next     = final_pass ? S_IDLE : S_APPEND;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.fin) begin
          final_pass_next = 1'b1;
          state_next      = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      final_pass <= 1'b0;
    end else begin
      state      <= state_next;
      final_pass <= final_pass_next;
    end
  end

endmodule
